@@ rtl/ovlt_pkg.sv @@
`default_nettype none
package ovlt_pkg;

    // Request operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_MODIFY = 2'd2;
    localparam logic [1:0] OP_DELETE = 2'd3;

    // Response status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Fixed field widths
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;   // latch request and key match vector
        logic execute;   // apply update and load response register
    } cmd_t;

endpackage
`default_nettype wire

@@ rtl/ovlt_ctrl.sv @@
`default_nettype none
module ovlt_ctrl (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              req_valid,
    output logic             req_stall,
    output logic             rsp_valid,
    input  wire              rsp_stall,
    output ovlt_pkg::cmd_t   cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;

    // Handshake decode
    always_comb
    begin
        req_stall   = (state_reg != S_IDLE);
        cmd.capture = req_valid && (state_reg == S_IDLE);
        cmd.execute = (state_reg == S_EXEC) && (!rsp_valid_reg || !rsp_stall);
    end

    // Next state and response valid
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.execute)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule
`default_nettype wire

@@ rtl/ovlt_dp.sv @@
`default_nettype none
module ovlt_dp #(
    parameter int DEPTH = 16
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire ovlt_pkg::cmd_t              cmd,
    input  wire [1:0]                        req_type,
    input  wire signed [ovlt_pkg::VALUE_W-1:0] key,
    input  wire signed [ovlt_pkg::VALUE_W-1:0] new_value,
    output logic [1:0]                       status,
    output logic [ovlt_pkg::COUNT_W-1:0]     count_after
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Entry cells and fill count
    logic [ovlt_pkg::VALUE_W-1:0] values_reg  [DEPTH];
    logic [ovlt_pkg::VALUE_W-1:0] values_next [DEPTH];
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;

    // Captured request
    logic [1:0]                   op_reg;
    logic [ovlt_pkg::VALUE_W-1:0] nv_reg;
    logic [DEPTH-1:0]             match_reg;
    logic [DEPTH-1:0]             match_next;

    // Response register
    logic [1:0]                   status_reg;
    logic [1:0]                   status_next;
    logic [ovlt_pkg::COUNT_W-1:0] count_after_reg;
    logic [ovlt_pkg::COUNT_W+CNT_W-1:0] count_wide;

    logic [DEPTH-1:0] neg_match;
    logic [DEPTH-1:0] first_hit;
    logic [DEPTH-1:0] at_or_above;

    // Every live cell compares the key at once
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            match_next[i] = (values_reg[i] == key) && (CNT_W'(i) < count_reg);
        end
    end

    // Lowest match as one-hot, and the mask of cells from it upward
    assign neg_match   = ~match_reg + DEPTH'(1);
    assign first_hit   = match_reg & neg_match;
    assign at_or_above = match_reg | neg_match;

    // Update of cells, count and status
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            values_next[i] = values_reg[i];
        end
        count_next  = count_reg;
        status_next = ovlt_pkg::ST_DONE;
        if (op_reg == ovlt_pkg::OP_INSERT)
        begin
            if (count_reg == CNT_W'(DEPTH))
            begin
                status_next = ovlt_pkg::ST_FULL;
            end
            else
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (count_reg == CNT_W'(i))
                    begin
                        values_next[i] = nv_reg;
                    end
                end
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (count_reg == '0)
        begin
            status_next = ovlt_pkg::ST_EMPTY;
        end
        else if (match_reg == '0)
        begin
            status_next = ovlt_pkg::ST_NOT_FOUND;
        end
        else if (op_reg == ovlt_pkg::OP_MODIFY)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (first_hit[i])
                begin
                    values_next[i] = nv_reg;
                end
            end
        end
        else if (op_reg == ovlt_pkg::OP_DELETE)
        begin
            // later entries move down one cell to close the gap
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                if (at_or_above[i])
                begin
                    values_next[i] = values_reg[i+1];
                end
            end
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign count_wide = {{ovlt_pkg::COUNT_W{1'b0}}, count_next};

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= req_type;
            nv_reg    <= new_value;
            match_reg <= match_next;
        end
        if (cmd.execute)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                values_reg[i] <= values_next[i];
            end
            status_reg      <= status_next;
            count_after_reg <= count_wide[ovlt_pkg::COUNT_W-1:0];
        end
    end

    // Fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.execute)
        begin
            count_reg <= count_next;
        end
    end

    assign status      = status_reg;
    assign count_after = count_after_reg;

endmodule
`default_nettype wire

@@ rtl/ordered_value_list_table.sv @@
`default_nettype none
// Channel   Handshake             Fields
// request   req_valid/req_stall   req_type, key, new_value
// response  rsp_valid/rsp_stall   status, count_after
//
// Each request first compares the key against all live cells at once when it is
// captured, then applies the insert, overwrite or parallel shift-down on execute.
// The response sits in an output register; the next request is taken while
// it waits, but a second response waits in the update cycle until it drains.
// Reset empties the list at once; the cell contents are not cleared.
module ordered_value_list_table #(
    parameter int DEPTH = 16
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 req_valid,
    output logic                                req_stall,
    input  wire [1:0]                           req_type,
    input  wire signed [ovlt_pkg::VALUE_W-1:0]  key,
    input  wire signed [ovlt_pkg::VALUE_W-1:0]  new_value,
    output logic                                rsp_valid,
    input  wire                                 rsp_stall,
    output logic [1:0]                          status,
    output logic [ovlt_pkg::COUNT_W-1:0]        count_after
);

    ovlt_pkg::cmd_t cmd;

    ovlt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    ovlt_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req_type    (req_type),
        .key         (key),
        .new_value   (new_value),
        .status      (status),
        .count_after (count_after)
    );

endmodule
`default_nettype wire
